// ----- rtl/core/gsr_pkg.sv -----
// Shared types, constants and GF(256) arithmetic for the Shamir recombiner.
package gsr_pkg;

    localparam int SLOT_W     = 4;
    localparam int SLOT_NUM   = 2 ** SLOT_W;
    localparam int CNT_W      = 5;
    localparam int FIFO_DEPTH = 4;
    localparam logic [CNT_W-1:0] SHARE_COUNT_RST = CNT_W'(16);
    localparam logic [8:0] GF_POLY = 9'h11d;

    typedef enum logic [1:0] {
        CMD_SET_X,
        CMD_MAC,
        CMD_FLUSH
    } t_cmd;

    typedef struct packed {
        t_cmd              kind;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
        logic              last_share;
        logic              last_byte;
    } t_cmd_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XI,
        ST_LOOP,
        ST_WEIGHT,
        ST_INV,
        ST_SCALE,
        ST_MAC,
        ST_EMIT
    } t_state;

    // shift-and-add product, reduced by the field polynomial
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                r = r ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ GF_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/gf256_shamir_recombine.sv -----
// Shamir share recombiner over GF(256), polynomial 0x11d: top level.
// Requests enter through push/full and results leave through empty/pop. A
// coordinate write is stored by the back part straight from the queue. A
// share byte for a live slot runs the weight sequencer: one table read per
// slot below share_count (capped at the table size), seven
// square-and-multiply steps for the inverse, then scale and accumulate; a
// byte that closes a position then emits its result. A flush-only byte goes
// straight to emitting. Up to four requests queue between the front and back
// parts, so the input keeps taking requests while the back part works.
// share_count must be written only while the block is idle.
module gf256_shamir_recombine
    import gsr_pkg::*;
#(
    parameter int MAX_SHARES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic              i_opcode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_share,
    input  logic              i_last_byte,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        o_secret_byte,
    output logic              o_secret_last
);

    logic [CNT_W-1:0] r_share_count;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    t_cmd_req         q_wr_req;
    t_cmd_req         q_rd_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_share_count <= SHARE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_share_count <= i_cfg_data;
        end
    end

    gsr_front #(
        .MAX_SHARES (MAX_SHARES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_share_count (r_share_count),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_slot        (i_slot),
        .i_data_byte   (i_data_byte),
        .i_last_share  (i_last_share),
        .i_last_byte   (i_last_byte),
        .o_q_push      (q_push),
        .o_q_req       (q_wr_req),
        .i_q_full      (q_full)
    );

    gsr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_wr_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_req   (q_rd_req),
        .o_empty (q_empty)
    );

    gsr_back #(
        .MAX_SHARES (MAX_SHARES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_share_count (r_share_count),
        .i_q_req       (q_rd_req),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_secret_byte (o_secret_byte),
        .o_secret_last (o_secret_last)
    );

endmodule

// ----- rtl/core/gsr_fifo.sv -----
// Short request queue between the front and back parts.
module gsr_fifo
    import gsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cmd_req i_req,
    output logic     o_full,
    input  logic     i_pop,
    output t_cmd_req o_req,
    output logic     o_empty
);

    localparam int PW = $clog2(FIFO_DEPTH);

    t_cmd_req      r_mem [FIFO_DEPTH];
    logic [PW:0]   r_wr_ptr;
    logic [PW:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[PW] != r_rd_ptr[PW]) &&
                     (r_wr_ptr[PW-1:0] == r_rd_ptr[PW-1:0]);
    assign o_req   = r_mem[r_rd_ptr[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[PW-1:0]] <= i_req;
        end
    end

endmodule

// ----- rtl/core/gsr_front.sv -----
// Front part: takes input requests, classifies them and drops those with no effect.
module gsr_front
    import gsr_pkg::*;
#(
    parameter int MAX_SHARES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_share_count,
    input  logic              push,
    output logic              full,
    input  logic              i_opcode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_share,
    input  logic              i_last_byte,
    output logic              o_q_push,
    output t_cmd_req          o_q_req,
    input  logic              i_q_full
);

    logic     r_valid;
    t_cmd_req r_req;
    logic     n_valid;
    t_cmd_req n_req;
    logic     keep;
    logic     accept;
    logic     slot_active;

    assign o_q_push = r_valid;
    assign o_q_req  = r_req;
    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;

    // slot below both the programmed count and the table size
    assign slot_active = ({1'b0, i_slot} < i_share_count) && (int'(i_slot) < MAX_SHARES);

    always_comb begin
        n_req.slot       = i_slot;
        n_req.data       = i_data_byte;
        n_req.last_share = i_last_share;
        n_req.last_byte  = i_last_byte;
        n_req.kind       = CMD_FLUSH;
        keep             = 1'b0;
        if (!i_opcode) begin
            n_req.kind = CMD_SET_X;
            keep       = int'(i_slot) < MAX_SHARES;
        end else if (slot_active && (i_data_byte != 8'h00)) begin
            n_req.kind = CMD_MAC;
            keep       = 1'b1;
        end else begin
            n_req.kind = CMD_FLUSH;
            keep       = i_last_share;
        end
    end

    always_comb begin
        n_valid = r_valid && i_q_full;
        if (accept && keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_req <= n_req;
        end
    end

endmodule

// ----- rtl/core/gsr_back.sv -----
// Back part: coordinate table, Lagrange weight sequencer, accumulator and result register.
module gsr_back
    import gsr_pkg::*;
#(
    parameter int MAX_SHARES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_share_count,
    input  t_cmd_req         i_q_req,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_secret_byte,
    output logic             o_secret_last
);

    localparam int DEPTH = (MAX_SHARES < SLOT_NUM) ? MAX_SHARES : SLOT_NUM;
    localparam int IW    = $clog2(DEPTH);

    t_state          r_state;
    t_state          n_state;
    t_cmd_req        r_req;
    logic [7:0]      r_xmem [DEPTH];
    logic [DEPTH-1:0] r_xvld;
    logic [7:0]      r_rd_data;
    logic [IW-1:0]   rd_addr;
    logic            mem_we;
    logic [7:0]      r_xi;
    logic [7:0]      r_top;
    logic [7:0]      r_bot;
    logic [IW-1:0]   r_j;
    logic [2:0]      r_k;
    logic [7:0]      r_base;
    logic [7:0]      r_inv;
    logic [7:0]      r_w;
    logic [7:0]      r_acc;
    logic            r_ovld;
    logic [7:0]      r_obyte;
    logic            r_olast;
    logic            out_load;
    logic [CNT_W-1:0] lim;
    logic            loop_last;

    assign lim       = (i_share_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : i_share_count;
    assign loop_last = (CNT_W'(r_j) + 1'b1) == lim;

    assign empty         = !r_ovld;
    assign o_secret_byte = r_obyte;
    assign o_secret_last = r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_req.kind)
                        CMD_SET_X: n_state = ST_IDLE;
                        CMD_MAC:   n_state = ST_XI;
                        default:   n_state = ST_EMIT;
                    endcase
                end
            end
            ST_XI: begin
                if (r_rd_data == 8'h00) begin
                    n_state = r_req.last_share ? ST_EMIT : ST_IDLE;
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_LOOP:   n_state = loop_last ? ST_WEIGHT : ST_LOOP;
            ST_WEIGHT: n_state = ST_INV;
            ST_INV:    n_state = (r_k == 3'd6) ? ST_SCALE : ST_INV;
            ST_SCALE:  n_state = ST_MAC;
            ST_MAC:    n_state = r_req.last_share ? ST_EMIT : ST_IDLE;
            ST_EMIT:   n_state = out_load ? ST_IDLE : ST_EMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        rd_addr  = '0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_q_pop = !i_q_empty;
                mem_we  = !i_q_empty && (i_q_req.kind == CMD_SET_X);
                rd_addr = i_q_req.slot[IW-1:0];
            end
            ST_LOOP: rd_addr = r_j + 1'b1;
            ST_EMIT: out_load = !r_ovld || pop;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_xvld  <= '0;
            r_acc   <= 8'h00;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_xvld[i_q_req.slot[IW-1:0]] <= 1'b1;
            end
            if (r_state == ST_MAC) begin
                r_acc <= r_acc ^ gf_mul(r_req.data, r_w);
            end else if (out_load) begin
                r_acc <= 8'h00;
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // coordinate table; an entry never written reads as empty
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_xmem[i_q_req.slot[IW-1:0]] <= i_q_req.data;
        end
        r_rd_data <= r_xvld[rd_addr] ? r_xmem[rd_addr] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_req;
        end
        if (out_load) begin
            r_obyte <= r_acc;
            r_olast <= r_req.last_byte;
        end
        case (r_state)
            ST_XI: begin
                r_xi  <= r_rd_data;
                r_top <= 8'h01;
                r_bot <= 8'h01;
                r_j   <= '0;
            end
            ST_LOOP: begin
                // equal coordinates (own slot included) and empty slots are skipped
                if ((r_rd_data != 8'h00) && (r_rd_data != r_xi)) begin
                    r_top <= gf_mul(r_top, r_rd_data);
                    r_bot <= gf_mul(r_bot, r_xi ^ r_rd_data);
                end
                r_j <= r_j + 1'b1;
            end
            ST_WEIGHT: begin
                r_base <= gf_mul(r_bot, r_bot);
                r_inv  <= 8'h01;
                r_k    <= 3'd0;
            end
            ST_INV: begin
                // b^254 = b^2 * b^4 * ... * b^128
                r_inv  <= gf_mul(r_inv, r_base);
                r_base <= gf_mul(r_base, r_base);
                r_k    <= r_k + 1'b1;
            end
            ST_SCALE: r_w <= gf_mul(r_top, r_inv);
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/gsr_checker.sv -----
// Port-level checks for the recombiner, bound to the top level.
module gsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_secret_byte,
    input logic       o_secret_last
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input shows full after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_secret_byte) && $stable(o_secret_last)))
        else $error("waiting result changed or vanished");

    // a result needs at least front stage, queue and back part to pass
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)))
        else $error("result appeared too soon after reset");

endmodule

bind gf256_shamir_recombine gsr_checker u_chk (.*);
